// File: rtl/core/kps_pkg.sv
// package for the matrix keypad scanner: types, register indexes and helpers
`timescale 1ns / 1ps
`default_nettype none

package kps_pkg;

  localparam int unsigned NUM_LINES   = 4;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned DEB_W       = 16;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned ROW_CODES_W = 32;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [CNT_W-1:0] ROWS_RST     = 3'd4;
  localparam logic [CNT_W-1:0] COLS_RST     = 3'd4;
  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd10;

  localparam int unsigned DEF_MAX_ROWS    = 4;
  localparam int unsigned DEF_MAX_COLUMNS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODES_R0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODES_R1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CODES_R2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CODES_R3  = 3'd6;

  typedef enum logic [1:0] {
    PH_SCAN     = 2'd0,
    PH_RELEASE  = 2'd1,
    PH_DEBOUNCE = 2'd2
  } scan_phase_t;

  typedef struct packed {
    logic [CNT_W-1:0]                       rows;
    logic [CNT_W-1:0]                       cols;
    logic [DEB_W-1:0]                       debounce;
    logic [NUM_LINES-1:0][ROW_CODES_W-1:0]  codes;
  } cfg_t;

  typedef struct packed {
    scan_phase_t         phase;
    logic [IDX_W-1:0]    col;
    logic [IDX_W-1:0]    row;
    logic [DEB_W-1:0]    deb_count;
    logic [CODE_W-1:0]   code;
    logic                found;
  } scan_state_t;

  typedef struct packed {
    logic [NUM_LINES-1:0] column_drive;
    logic                 pass_done;
    logic                 key_found;
    logic [CODE_W-1:0]    key_code;
  } scan_result_t;

  // count register clamped to 1..lim
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] c;
    c = (v == '0) ? CNT_W'(1) : v;
    return (c > lim) ? lim : c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/kps_cfg.sv
// configuration register file of the keypad scanner
`timescale 1ns / 1ps
`default_nettype none

module kps_cfg
  import kps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ROWS:     cfg_nxt.rows     = cfg_data[CNT_W-1:0];
        REG_COLUMNS:  cfg_nxt.cols     = cfg_data[CNT_W-1:0];
        REG_DEBOUNCE: cfg_nxt.debounce = cfg_data[DEB_W-1:0];
        REG_CODES_R0: cfg_nxt.codes[0] = cfg_data[ROW_CODES_W-1:0];
        REG_CODES_R1: cfg_nxt.codes[1] = cfg_data[ROW_CODES_W-1:0];
        REG_CODES_R2: cfg_nxt.codes[2] = cfg_data[ROW_CODES_W-1:0];
        REG_CODES_R3: cfg_nxt.codes[3] = cfg_data[ROW_CODES_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows     <= ROWS_RST;
      cfg_r.cols     <= COLS_RST;
      cfg_r.debounce <= DEBOUNCE_RST;
      cfg_r.codes    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/core/kps_step.sv
// next-state and result logic for one scan tick
`timescale 1ns / 1ps
`default_nettype none

module kps_step
  import kps_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  cfg_t                       cfg,
  input  scan_state_t                st,
  input  wire logic [NUM_LINES-1:0]  row_levels,
  output scan_state_t                st_nxt,
  output scan_result_t               res
);

  localparam int unsigned ROW_LIM_I = (MAX_ROWS < NUM_LINES) ? MAX_ROWS : NUM_LINES;
  localparam int unsigned COL_LIM_I = (MAX_COLUMNS < NUM_LINES) ? MAX_COLUMNS : NUM_LINES;
  localparam logic [CNT_W-1:0] ROW_LIM = CNT_W'((ROW_LIM_I < 1) ? 1 : ROW_LIM_I);
  localparam logic [CNT_W-1:0] COL_LIM = CNT_W'((COL_LIM_I < 1) ? 1 : COL_LIM_I);

  logic [CNT_W-1:0]  rows;
  logic [CNT_W-1:0]  cols;
  logic              row_low;
  logic [IDX_W-1:0]  row_inc;
  logic [IDX_W-1:0]  col_inc;
  logic              row_wrap;
  logic              col_wrap;
  logic [IDX_W-1:0]  adv_row;
  logic [IDX_W-1:0]  adv_col;
  logic              adv_done;
  logic [DEB_W-1:0]  deb_dec;
  logic [CODE_W-1:0] table_code;
  logic              advance;
  logic              done;

  assign rows    = clamp_count(cfg.rows, ROW_LIM);
  assign cols    = clamp_count(cfg.cols, COL_LIM);
  assign row_low = ~row_levels[st.row];

  // row then column stepping
  assign row_inc  = st.row + IDX_W'(1);
  assign col_inc  = st.col + IDX_W'(1);
  assign row_wrap = (row_inc == '0) || ({1'b0, row_inc} >= rows);
  assign col_wrap = (col_inc == '0) || ({1'b0, col_inc} >= cols);
  assign adv_row  = row_wrap ? '0 : row_inc;
  assign adv_col  = row_wrap ? (col_wrap ? '0 : col_inc) : st.col;
  assign adv_done = row_wrap && col_wrap;

  assign deb_dec    = st.deb_count - DEB_W'(1);
  assign table_code = CODE_W'(cfg.codes[st.row] >> {st.col, 3'b000});

  always_comb begin
    st_nxt  = st;
    advance = 1'b0;
    case (st.phase)
      PH_RELEASE: begin
        if (!row_low) begin
          if (cfg.debounce == '0) begin
            advance = 1'b1;
          end else begin
            st_nxt.deb_count = cfg.debounce;
            st_nxt.phase     = PH_DEBOUNCE;
          end
        end
      end
      PH_DEBOUNCE: begin
        st_nxt.deb_count = deb_dec;
        if (deb_dec == '0) begin
          advance = 1'b1;
        end
      end
      default: begin
        if (({1'b0, st.row} < rows) && ({1'b0, st.col} < cols) && row_low) begin
          st_nxt.code  = table_code;
          st_nxt.found = 1'b1;
          st_nxt.phase = PH_RELEASE;
        end else begin
          advance = 1'b1;
        end
      end
    endcase

    done = advance && adv_done;
    if (advance) begin
      st_nxt.phase = PH_SCAN;
      st_nxt.row   = adv_row;
      st_nxt.col   = adv_col;
    end
    if (done) begin
      st_nxt.found = 1'b0;
      st_nxt.code  = '0;
    end
  end

  always_comb begin
    res.column_drive = ~(NUM_LINES'(1) << st.col);
    res.pass_done    = done;
    res.key_found    = done && st.found;
    res.key_code     = (done && st.found) ? st.code : '0;
  end

endmodule

`default_nettype wire

// File: rtl/core/matrix_keypad_scanner.sv
// top level of the matrix keypad scanner: scan state, output register, checks
//
//  channel   signals                                        direction
//  in        in_valid, in_ready, in_row_levels              tick in
//  out       out_valid, out_ready, out_column_drive,
//            out_pass_done, out_key_found, out_key_code     result out
//  cfg       cfg_we, cfg_index, cfg_data                    register write
//
// one result per input tick, one tick per cycle when out_ready stays high
// the result is registered: the scan state and output register update together
// in_ready = !out_valid || out_ready, so a stall on out holds one result only
// synchronous active-low reset restores config registers, scan state and out_valid
`timescale 1ns / 1ps
`default_nettype none

module matrix_keypad_scanner
  import kps_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [NUM_LINES-1:0]  in_row_levels,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [NUM_LINES-1:0]       out_column_drive,
  output logic                       out_pass_done,
  output logic                       out_key_found,
  output logic [CODE_W-1:0]          out_key_code,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t         cfg;
  scan_state_t  st_r;
  scan_state_t  st_nxt;
  scan_result_t res;
  scan_result_t res_r;
  logic         out_valid_r;
  logic         in_xact;

  kps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kps_step #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_step (
    .cfg        (cfg),
    .st         (st_r),
    .row_levels (in_row_levels),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_xact  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase     <= PH_SCAN;
      st_r.col       <= '0;
      st_r.row       <= '0;
      st_r.deb_count <= '0;
      st_r.code      <= '0;
      st_r.found     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_xact) begin
        st_r <= st_nxt;
      end
      if (in_xact) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xact) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column_drive = res_r.column_drive;
  assign out_pass_done    = res_r.pass_done;
  assign out_key_found    = res_r.key_found;
  assign out_key_code     = res_r.key_code;

`ifndef ASSERT_OFF
  a_one_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(~out_column_drive) == 1))
    else $error("column drive must have exactly one active column");

  a_quiet_mid_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pass_done) |-> (!out_key_found && (out_key_code == '0)))
    else $error("key report outside pass completion");

  a_debounce_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_DEBOUNCE) |-> (st_r.deb_count != '0))
    else $error("debounce phase with zero count");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(in_xact) && $past(rst_n) |-> $stable(st_r))
    else $error("scan state changed without an input transaction");
`endif

endmodule

`default_nettype wire
